>>> rtl/hsvr_pkg.sv
// Package for the HSV to RGB converter: channel widths, hue sector constants,
// reciprocal constants for the rounding dividers, sector codes and a control struct.
// No dependencies.
`timescale 1ns / 1ps

package hsvr_pkg;

  // Channel width; CH_MAX stands for 1.0
  localparam int CHANNEL_BITS = 8;
  localparam int HUE_BITS     = 15;
  localparam int HUE_SECTOR   = 60 * 64;
  localparam int REM_BITS     = $clog2(HUE_SECTOR);
  // Highest sector number that a hue field can reach
  localparam int SECTOR_LAST  = ((1 << HUE_BITS) - 1) / HUE_SECTOR;

  localparam longint unsigned CH_MAX     = (64'd1 << CHANNEL_BITS) - 64'd1;
  localparam longint unsigned FULL_SCALE = CH_MAX * HUE_SECTOR;
  localparam int FULL_W = CHANNEL_BITS + REM_BITS;

  // Divide by FULL_SCALE: numerator width, reciprocal and its shift
  localparam int QN_W = 2 * CHANNEL_BITS + REM_BITS;
  localparam int KQ   = QN_W + 1;
  localparam longint unsigned RQ = (64'd1 << KQ) / FULL_SCALE;
  localparam int RQ_W = $clog2(RQ + 64'd1);
  localparam longint unsigned HALF_FULL = FULL_SCALE / 2;

  // Divide by CH_MAX
  localparam int PN_W = 2 * CHANNEL_BITS;
  localparam int KP   = PN_W + 1;
  localparam longint unsigned RP = (64'd1 << KP) / CH_MAX;
  localparam int RP_W = $clog2(RP + 64'd1);
  localparam longint unsigned HALF_MAX = CH_MAX / 2;

  typedef logic [CHANNEL_BITS-1:0] chan_t;

  // 60-degree sectors, named by the colors they span
  typedef enum logic [2:0] {
    SEC_R_Y = 3'd0,
    SEC_Y_G = 3'd1,
    SEC_G_C = 3'd2,
    SEC_C_B = 3'd3,
    SEC_B_M = 3'd4,
    SEC_M_R = 3'd5
  } sector_e;

  // Load enables for the two stages of a rounding divider
  typedef struct packed {
    logic est_en;
    logic fix_en;
  } div_en_t;

endpackage

>>> rtl/hsvr_hsv_if.sv
// Input channel of the HSV to RGB converter: valid/ready plus hue, saturation, value.
// Depends on hsvr_pkg.
`timescale 1ns / 1ps

interface hsvr_hsv_if;
  import hsvr_pkg::*;

  logic                valid;
  logic                ready;
  logic [HUE_BITS-1:0] hue;
  chan_t               saturation;
  chan_t               brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

>>> rtl/hsvr_rgb_if.sv
// Output channel of the HSV to RGB converter: valid/ready plus red, green, blue.
// Depends on hsvr_pkg.
`timescale 1ns / 1ps

interface hsvr_rgb_if;
  import hsvr_pkg::*;

  logic  valid;
  logic  ready;
  chan_t red;
  chan_t green;
  chan_t blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

>>> rtl/hsvr_qdiv.sv
// Two-stage rounding divider by FULL_SCALE: reciprocal estimate, then one-step fix.
// Depends on hsvr_pkg.
`timescale 1ns / 1ps

module hsvr_qdiv (
  input  logic                      clk_i,
  input  hsvr_pkg::div_en_t         en_i,
  input  logic [hsvr_pkg::QN_W-1:0] num_i,
  output hsvr_pkg::chan_t           quo_o
);
  import hsvr_pkg::*;

  logic [QN_W+RQ_W-1:0] est_prod;
  chan_t                est_d, est_q;
  logic [QN_W-1:0]      num_q;
  logic [QN_W-1:0]      back_prod;
  logic [QN_W-1:0]      resid;
  chan_t                quo_d, quo_q;

  // Estimate is the true quotient or one below it
  assign est_prod = (QN_W + RQ_W)'(num_i) * (QN_W + RQ_W)'(RQ);
  assign est_d    = est_prod[KQ +: CHANNEL_BITS];

  always_ff @(posedge clk_i) begin
    if (en_i.est_en) begin
      est_q <= est_d;
      num_q <= num_i;
    end
  end

  assign back_prod = QN_W'(est_q) * QN_W'(FULL_SCALE);
  assign resid     = num_q - back_prod;
  assign quo_d     = est_q + CHANNEL_BITS'(resid >= QN_W'(FULL_SCALE));

  always_ff @(posedge clk_i) begin
    if (en_i.fix_en) begin
      quo_q <= quo_d;
    end
  end

  assign quo_o = quo_q;

endmodule

>>> rtl/hsv_to_rgb_converter.sv
// HSV to RGB converter, six-stage pipeline: hue split, s products, v products,
// reciprocal estimate, rounding fix, sector select into the output register.
// Throughput: one beat per cycle while the receiver holds ready high.
// Reset clears only the stage valid bits; payload registers are not reset.
`timescale 1ns / 1ps

module hsv_to_rgb_converter (
  input  logic clk_i,
  input  logic rst_ni,
  hsvr_hsv_if.sink   hsv_i,
  hsvr_rgb_if.source rgb_o
);
  import hsvr_pkg::*;

  // Stage valid bits and load enables. en[k] loads stage k; en[7] is the
  // downstream ready. A stage loads when it is empty or its beat moves on.
  logic [6:1] vld_q;
  logic [7:1] en;

  always_comb begin
    en[7] = rgb_o.ready;
    for (int k = 6; k >= 1; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign hsv_i.ready = en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[1]) vld_q[1] <= hsv_i.valid;
      for (int k = 2; k <= 6; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: split hue into sector and remainder. Sectors past the last real
  // one fold onto the magenta-red mapping but keep their own remainder.
  // ---------------------------------------------------------------------------
  logic [HUE_BITS-1:0] base;
  sector_e             sec_d;
  logic [REM_BITS-1:0] rem_d;

  sector_e             sec_q1;
  logic [REM_BITS-1:0] rem_q1;
  chan_t               sat_q1, val_q1;

  always_comb begin
    base  = '0;
    sec_d = SEC_R_Y;
    for (int k = 1; k <= SECTOR_LAST; k++) begin
      if (hsv_i.hue >= HUE_BITS'(k * HUE_SECTOR)) begin
        base  = HUE_BITS'(k * HUE_SECTOR);
        sec_d = (k >= int'(SEC_M_R)) ? SEC_M_R : sector_e'(3'(k));
      end
    end
    rem_d = REM_BITS'(hsv_i.hue - base);
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      sec_q1 <= sec_d;
      rem_q1 <= rem_d;
      sat_q1 <= hsv_i.saturation;
      val_q1 <= hsv_i.brightness;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: s*f and s*(1-f) in hue units, and 1-s
  // ---------------------------------------------------------------------------
  logic [FULL_W-1:0] sf_q2, sg_q2;
  chan_t             inv_s_q2, val_q2;
  sector_e           sec_q2;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      sf_q2    <= FULL_W'(sat_q1) * FULL_W'(rem_q1);
      sg_q2    <= FULL_W'(sat_q1) * FULL_W'(REM_BITS'(HUE_SECTOR) - rem_q1);
      inv_s_q2 <= CHANNEL_BITS'(CH_MAX) - sat_q1;
      val_q2   <= val_q1;
      sec_q2   <= sec_q1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: scale by v and add half the divisor for round-to-nearest
  // ---------------------------------------------------------------------------
  logic [FULL_W-1:0] dq, dt;
  logic [QN_W-1:0]   nq_q3, nt_q3;
  logic [PN_W-1:0]   np_q3;
  chan_t             val_q3;
  sector_e           sec_q3;

  assign dq = FULL_W'(FULL_SCALE) - sf_q2;
  assign dt = FULL_W'(FULL_SCALE) - sg_q2;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      nq_q3  <= QN_W'(val_q2) * QN_W'(dq) + QN_W'(HALF_FULL);
      nt_q3  <= QN_W'(val_q2) * QN_W'(dt) + QN_W'(HALF_FULL);
      np_q3  <= PN_W'(val_q2) * PN_W'(inv_s_q2) + PN_W'(HALF_MAX);
      val_q3 <= val_q2;
      sec_q3 <= sec_q2;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 4 and 5: divide. q and t by FULL_SCALE in the divider units,
  // p by CH_MAX inline with the same estimate-then-fix scheme.
  // ---------------------------------------------------------------------------
  div_en_t div_en;
  chan_t   q_val, t_val;

  assign div_en.est_en = en[4];
  assign div_en.fix_en = en[5];

  hsvr_qdiv u_div_q (
    .clk_i (clk_i),
    .en_i  (div_en),
    .num_i (nq_q3),
    .quo_o (q_val)
  );

  hsvr_qdiv u_div_t (
    .clk_i (clk_i),
    .en_i  (div_en),
    .num_i (nt_q3),
    .quo_o (t_val)
  );

  logic [PN_W+RP_W-1:0] p_prod;
  chan_t                p_est_q4;
  logic [PN_W-1:0]      np_q4;
  logic [PN_W-1:0]      p_back, p_resid;
  chan_t                p_q5;
  chan_t                val_q4, val_q5;
  sector_e              sec_q4, sec_q5;

  assign p_prod = (PN_W + RP_W)'(np_q3) * (PN_W + RP_W)'(RP);

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      p_est_q4 <= p_prod[KP +: CHANNEL_BITS];
      np_q4    <= np_q3;
      val_q4   <= val_q3;
      sec_q4   <= sec_q3;
    end
  end

  assign p_back  = PN_W'(p_est_q4) * PN_W'(CH_MAX);
  assign p_resid = np_q4 - p_back;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      p_q5   <= p_est_q4 + CHANNEL_BITS'(p_resid >= PN_W'(CH_MAX));
      val_q5 <= val_q4;
      sec_q5 <= sec_q4;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: place v, p, q, t onto the channels. Zero saturation needs no
  // special path: p, q and t all come out equal to v.
  // ---------------------------------------------------------------------------
  chan_t red_d, green_d, blue_d;
  chan_t red_q, green_q, blue_q;

  always_comb begin
    unique case (sec_q5)
      SEC_R_Y: begin red_d = val_q5; green_d = t_val;  blue_d = p_q5;   end
      SEC_Y_G: begin red_d = q_val;  green_d = val_q5; blue_d = p_q5;   end
      SEC_G_C: begin red_d = p_q5;   green_d = val_q5; blue_d = t_val;  end
      SEC_C_B: begin red_d = p_q5;   green_d = q_val;  blue_d = val_q5; end
      SEC_B_M: begin red_d = t_val;  green_d = p_q5;   blue_d = val_q5; end
      default: begin red_d = val_q5; green_d = p_q5;   blue_d = q_val;  end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign rgb_o.valid = vld_q[6];
  assign rgb_o.red   = red_q;
  assign rgb_o.green = green_q;
  assign rgb_o.blue  = blue_q;

endmodule

>>> tb/sv/hsv_to_rgb_converter_tb.sv
// Self-checking testbench for the HSV to RGB converter: directed corner pixels, then
// random pixels with random idling on both channels, checked against a local predictor.
// Depends on hsvr_pkg, hsvr_hsv_if, hsvr_rgb_if and hsv_to_rgb_converter.
`timescale 1ns / 1ps

module hsv_to_rgb_converter_tb;
  import hsvr_pkg::*;

  localparam int N_RANDOM     = 1930;
  localparam int MAX_GAP      = 13;
  // Receiver stall that backs the pipeline up into the input channel
  localparam int HOLD_AT      = 600;
  localparam int HOLD_CYCLES  = 300;
  // Cycles with no beat on either channel before the run is abandoned
  localparam int IDLE_LIMIT   = 3000;
  // Allow room for the pipeline and a full receiver gap before the final verdict
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS  = 10;

  localparam longint unsigned HUE_SCALE = CH_MAX * HUE_SECTOR;
  // Full-scale channel code as a stimulus value
  localparam int unsigned     CH_FULL   = 32'(CH_MAX);

  typedef logic [HUE_BITS-1:0] hue_t;

  typedef struct {
    hue_t  hue;
    chan_t sat;
    chan_t val;
  } hsv_pixel_t;

  typedef struct {
    hsv_pixel_t src;
    chan_t      red;
    chan_t      green;
    chan_t      blue;
  } rgb_pixel_t;

  // Hold the expected colors of accepted pixels in order and grade each output beat.
  class rgb_scoreboard;
    rgb_pixel_t  pending[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Round to nearest, halves up
    function automatic longint unsigned round_div(longint unsigned num, longint unsigned den);
      return (num + den / 2) / den;
    endfunction

    function automatic rgb_pixel_t predict_rgb(hsv_pixel_t px);
      longint unsigned s, v, sec, frac, p, q, t;
      rgb_pixel_t      res;
      res.src = px;
      s = px.sat;
      v = px.val;
      // Zero saturation is pure grey, whatever the hue
      if (s == 0) begin
        res.red   = px.val;
        res.green = px.val;
        res.blue  = px.val;
        return res;
      end
      sec  = px.hue / HUE_SECTOR;
      frac = px.hue - sec * HUE_SECTOR;
      p = round_div(v * (CH_MAX - s), CH_MAX);
      q = round_div(v * (HUE_SCALE - s * frac), HUE_SCALE);
      t = round_div(v * (HUE_SCALE - s * (HUE_SECTOR - frac)), HUE_SCALE);
      // Hues past 360 degrees fall through to the magenta-red mapping
      case (sec)
        SEC_R_Y: begin res.red = v[CHANNEL_BITS-1:0]; res.green = t[CHANNEL_BITS-1:0];
                       res.blue = p[CHANNEL_BITS-1:0]; end
        SEC_Y_G: begin res.red = q[CHANNEL_BITS-1:0]; res.green = v[CHANNEL_BITS-1:0];
                       res.blue = p[CHANNEL_BITS-1:0]; end
        SEC_G_C: begin res.red = p[CHANNEL_BITS-1:0]; res.green = v[CHANNEL_BITS-1:0];
                       res.blue = t[CHANNEL_BITS-1:0]; end
        SEC_C_B: begin res.red = p[CHANNEL_BITS-1:0]; res.green = q[CHANNEL_BITS-1:0];
                       res.blue = v[CHANNEL_BITS-1:0]; end
        SEC_B_M: begin res.red = t[CHANNEL_BITS-1:0]; res.green = p[CHANNEL_BITS-1:0];
                       res.blue = v[CHANNEL_BITS-1:0]; end
        default: begin res.red = v[CHANNEL_BITS-1:0]; res.green = p[CHANNEL_BITS-1:0];
                       res.blue = q[CHANNEL_BITS-1:0]; end
      endcase
      return res;
    endfunction

    function void note_pixel(hsv_pixel_t px);
      pending.insert(pending.size(), predict_rgb(px));
    endfunction

    function void check_pixel(chan_t red, chan_t green, chan_t blue);
      rgb_pixel_t exp_px;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected rgb beat %0d/%0d/%0d with no pixel pending", red, green, blue);
        return;
      end
      exp_px = pending.pop_front();
      if (red !== exp_px.red || green !== exp_px.green || blue !== exp_px.blue) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch h=%0d s=%0d v=%0d: expected rgb %0d/%0d/%0d, got %0d/%0d/%0d",
                   exp_px.src.hue, exp_px.src.sat, exp_px.src.val,
                   exp_px.red, exp_px.green, exp_px.blue, red, green, blue);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   stim_done;

  hsvr_hsv_if hsv_if ();
  hsvr_rgb_if rgb_if ();

  rgb_scoreboard sb = new();
  hsv_pixel_t    pixel_plan[$];

  hsv_to_rgb_converter u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .hsv_i (hsv_if),
    .rgb_o (rgb_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic void plan_pixel(int unsigned hue, int unsigned sat, int unsigned val);
    hsv_pixel_t px;
    px.hue = hue[HUE_BITS-1:0];
    px.sat = sat[CHANNEL_BITS-1:0];
    px.val = val[CHANNEL_BITS-1:0];
    pixel_plan.insert(pixel_plan.size(), px);
  endfunction

  // Idle cycles before a beat; every fourth stretch of 128 beats runs back to back.
  function automatic int draw_gap(int idx);
    if ((idx / 128) % 4 == 2) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  // Input side: build the pixel list, then offer pixels at falling edges.
  initial begin : drive_pixels
    int          gap;
    int unsigned hue, sat, val;
    hsv_pixel_t  px;
    hsv_if.valid      <= 1'b0;
    hsv_if.hue        <= '0;
    hsv_if.saturation <= '0;
    hsv_if.brightness <= '0;

    // Black, grey at two levels and greys at odd hues
    plan_pixel(0, 0, 0);
    plan_pixel(12345, 0, CH_FULL);
    plan_pixel(32767, 0, 128);
    // Fully saturated colors at the start of every sector
    for (int k = 0; k < 6; k++) plan_pixel(k * HUE_SECTOR, CH_FULL, CH_FULL);
    // Last hue of a sector, the last in-range hue, and a half-way fraction
    plan_pixel(HUE_SECTOR - 1, CH_FULL, CH_FULL);
    plan_pixel(6 * HUE_SECTOR - 1, CH_FULL, CH_FULL);
    plan_pixel(HUE_SECTOR / 2, 128, 200);
    // Hues past 360 degrees: sectors 6, 7, 8 and the top of the field
    plan_pixel(6 * HUE_SECTOR, 200, 180);
    plan_pixel(7 * HUE_SECTOR + 1000, 200, 180);
    plan_pixel(8 * HUE_SECTOR, CH_FULL, CH_FULL);
    plan_pixel(32767, CH_FULL, CH_FULL);
    // Zero value, minimum saturation, rounding near halves
    plan_pixel(5000, CH_FULL, 0);
    plan_pixel(9000, 1, CH_FULL);
    plan_pixel(17000, 127, 1);
    plan_pixel(21111, 254, 254);

    for (int i = 0; i < N_RANDOM; i++) begin
      case ($urandom_range(0, 9))
        0:       hue = $urandom_range(0, (1 << HUE_BITS) - 1);
        1:       hue = $urandom_range(1, 8) * HUE_SECTOR + $urandom_range(0, 2) - 1;
        default: hue = $urandom_range(0, 6 * HUE_SECTOR - 1);
      endcase
      case ($urandom_range(0, 9))
        0:       sat = 0;
        1:       sat = CH_FULL;
        default: sat = $urandom_range(0, CH_FULL);
      endcase
      case ($urandom_range(0, 9))
        0:       val = 0;
        1:       val = CH_FULL;
        default: val = $urandom_range(0, CH_FULL);
      endcase
      plan_pixel(hue, sat, val);
    end

    wait (rst_ni === 1'b1);
    foreach (pixel_plan[i]) begin
      px  = pixel_plan[i];
      gap = draw_gap(i);
      // Drop valid for the gap, then raise it with the next pixel
      if (gap > 0) begin
        @(negedge clk_i);
        hsv_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      hsv_if.valid      <= 1'b1;
      hsv_if.hue        <= px.hue;
      hsv_if.saturation <= px.sat;
      hsv_if.brightness <= px.val;
      // Hold the beat until the block takes it
      do @(posedge clk_i); while (hsv_if.ready !== 1'b1);
      sb.note_pixel(px);
    end
    @(negedge clk_i);
    hsv_if.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Output side: random ready gaps, one long hold-off, grade every beat.
  initial begin : sink_pixels
    int gap;
    int n;
    rgb_if.ready <= 1'b0;
    n = 0;
    wait (rst_ni === 1'b1);
    forever begin
      if (n == HOLD_AT) begin
        // Stall the output long enough for the pipeline to fill and push back
        @(negedge clk_i);
        rgb_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else begin
        gap = draw_gap(n);
        if (gap > 0) begin
          @(negedge clk_i);
          rgb_if.ready <= 1'b0;
          repeat (gap - 1) @(negedge clk_i);
        end
      end
      @(negedge clk_i);
      rgb_if.ready <= 1'b1;
      do @(posedge clk_i); while (rgb_if.valid !== 1'b1);
      sb.check_pixel(rgb_if.red, rgb_if.green, rgb_if.blue);
      n++;
    end
  end

  // Abandon the run when neither channel moves a beat for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    wait (rst_ni === 1'b1);
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((hsv_if.valid === 1'b1 && hsv_if.ready === 1'b1) ||
          (rgb_if.valid === 1'b1 && rgb_if.ready === 1'b1))
        idle = 0;
      else
        idle++;
    end
    $display("[hsv_to_rgb_converter] ERROR");
    $finish;
  end

  // Reset once, wait out stimulus and drain, then give the verdict.
  initial begin : run_control
    rst_ni <= 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_done);
    while (sb.pending.size() != 0) @(posedge clk_i);
    // Leave room for any stray beat to show up
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("[hsv_to_rgb_converter] OK");
    end else begin
      $display("[hsv_to_rgb_converter] ERROR");
    end
    $finish;
  end

endmodule
